[sv/fragment_reassembly_engine_defines.svh]
// Assertion helpers shared by the reassembly engine.
`ifndef FRAGMENT_REASSEMBLY_ENGINE_DEFINES_SVH
`define FRAGMENT_REASSEMBLY_ENGINE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FRE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[sv/fre_pkg.sv]
package fre_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 64;
  localparam int unsigned MAX_FRAGS_DEF     = 16;
  localparam int unsigned LEN_W             = 11;

  localparam logic [1:0] CMD_FRAG = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] KIND_VERDICT = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  localparam logic [1:0] RD_OK           = 2'd0;
  localparam logic [1:0] RD_NOT_COMPLETE = 2'd1;
  localparam logic [1:0] RD_EMPTY        = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  frag_num;
    logic [7:0]  total;
    logic [7:0]  seq_id;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last_byte;
    logic [31:0] now;
  } fre_req_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             complete;
    logic             accepted;
    logic             expired;
    logic [7:0]       out_byte;
    logic             out_last;
    logic [1:0]       read_status;
    logic [LEN_W-1:0] msg_len;
  } fre_rsp_t;

endpackage

[sv/fragment_reassembly_engine.sv]
// Rebuilds one message from fragments that arrive in any order. A fragment
// byte request is taken straight from the idle state. The request that closes
// a fragment returns its verdict at once; when it adds a new fragment of n
// bytes the staged bytes are then copied through the staging memory into the
// message memory, one byte a cycle, and the engine takes no request until the
// copy ends. A tick is answered straight from the idle state, and so is a read
// that finds the message incomplete or empty. A read that returns a byte waits
// on the message memory read and steps past every used-up fragment slot,
// wrapping back to the first slot after the last one.
// No request is taken while a result waits and the output is stalled.
module fragment_reassembly_engine
  import fre_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  parameter int unsigned MAX_FRAGS     = MAX_FRAGS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  fre_req_t    in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output fre_rsp_t    out_rsp_o
);

`include "fragment_reassembly_engine_defines.svh"

  localparam int unsigned STG_AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int unsigned CNT_W  = $clog2(PAYLOAD_BYTES + 1);
  localparam int unsigned SLOT_W = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
  localparam int unsigned FCNT_W = $clog2(MAX_FRAGS + 1);
  localparam int unsigned MSG_D  = MAX_FRAGS * PAYLOAD_BYTES;
  localparam int unsigned MSG_AW = (MSG_D > 1) ? $clog2(MSG_D) : 1;
  localparam int unsigned SUM_W  = $clog2(MSG_D + 1);

  typedef enum logic [2:0] {S_IDLE, S_COPY, S_SEEK1, S_SEEK2} state_e;

  function automatic logic [MAX_FRAGS-1:0] full_mask(input logic [FCNT_W-1:0] e);
    logic [MAX_FRAGS:0] w;
    w = (MAX_FRAGS + 1)'(1) << e;
    w = w - (MAX_FRAGS + 1)'(1);
    return w[MAX_FRAGS-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] to_len(input logic [SUM_W-1:0] s);
    logic [SUM_W+LEN_W-1:0] w;
    w = (SUM_W + LEN_W)'(s);
    return w[LEN_W-1:0];
  endfunction

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      stg_cnt_q, stg_cnt_d;
  logic                  ovf_q, ovf_d;
  logic [MAX_FRAGS-1:0]  bits_q, bits_d;
  logic [FCNT_W-1:0]     exp_q, exp_d;
  logic [7:0]            seq_q, seq_d;
  logic [31:0]           stamp_q, stamp_d;
  logic                  busy_q, busy_d;
  logic [FCNT_W-1:0]     rs_q, rs_d;
  logic [CNT_W-1:0]      off_q, off_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [31:0]           timeout_q;
  logic [CNT_W-1:0]      n_q, n_d;
  logic [CNT_W-1:0]      rd_q, rd_d;
  logic                  pend_q, pend_d;
  logic [STG_AW-1:0]     pend_a_q, pend_a_d;
  logic [MSG_AW-1:0]     base_q, base_d;
  logic                  out_valid_q, out_valid_d;
  fre_rsp_t              out_q, out_d;

  logic [CNT_W-1:0]      len_q [MAX_FRAGS];
  logic                  len_we;
  logic [SLOT_W-1:0]     len_wa;
  logic [CNT_W-1:0]      len_wd;

  logic                  stg_we, stg_re;
  logic [STG_AW-1:0]     stg_wa, stg_ra;
  logic [7:0]            stg_rdata;
  logic                  msg_we, msg_re;
  logic [MSG_AW-1:0]     msg_wa, msg_ra;
  logic [7:0]            msg_rdata;

  logic                  in_acc;
  logic                  stg_room;
  logic [CNT_W-1:0]      cnt_new;
  logic                  ovf_new;
  logic [SLOT_W-1:0]     idx_s;
  logic [SLOT_W-1:0]     rs_idx;
  logic                  complete_now;
  logic                  seek_step;
  logic                  seek_end;
  logic [31:0]           age;

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign stg_room = stg_cnt_q < CNT_W'(PAYLOAD_BYTES);
  assign cnt_new  = (in_req_i.has_byte && stg_room) ? stg_cnt_q + CNT_W'(1) : stg_cnt_q;
  assign ovf_new  = ovf_q || (in_req_i.has_byte && !stg_room);
  assign idx_s    = in_req_i.frag_num[SLOT_W-1:0];
  assign rs_idx   = rs_q[SLOT_W-1:0];
  assign age      = in_req_i.now - stamp_q;

  assign complete_now = busy_q && (exp_q != '0) && (bits_q == full_mask(exp_q));
  // Step past a slot whose bytes are used up; the slot index only counts when in range.
  assign seek_end     = rs_q >= exp_q;
  assign seek_step    = !seek_end && (off_q >= len_q[rs_idx]);

  always_comb begin
    logic                 ok;
    logic                 comp;
    logic [FCNT_W-1:0]    e_v;
    logic [MAX_FRAGS-1:0] b_v;
    logic [SUM_W-1:0]     s_v;
    logic                 keep;
    fre_rsp_t             rsp;
    logic                 produce;

    state_d   = state_q;
    stg_cnt_d = stg_cnt_q;
    ovf_d     = ovf_q;
    bits_d    = bits_q;
    exp_d     = exp_q;
    seq_d     = seq_q;
    stamp_d   = stamp_q;
    busy_d    = busy_q;
    rs_d      = rs_q;
    off_d     = off_q;
    sum_d     = sum_q;
    n_d       = n_q;
    rd_d      = rd_q;
    pend_d    = 1'b0;
    pend_a_d  = pend_a_q;
    base_d    = base_q;
    stg_we    = 1'b0;
    stg_wa    = stg_cnt_q[STG_AW-1:0];
    stg_re    = 1'b0;
    stg_ra    = rd_q[STG_AW-1:0];
    msg_we    = 1'b0;
    msg_wa    = base_q + MSG_AW'(pend_a_q);
    msg_re    = 1'b0;
    msg_ra    = MSG_AW'(rs_idx) * MSG_AW'(PAYLOAD_BYTES) + MSG_AW'(off_q);
    len_we    = 1'b0;
    len_wa    = idx_s;
    len_wd    = cnt_new;
    ok        = 1'b0;
    comp      = 1'b0;
    e_v       = exp_q;
    b_v       = bits_q;
    s_v       = sum_q;
    keep      = 1'b0;
    rsp       = '0;
    produce   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_req_i.cmd)
            CMD_FRAG: begin
              stg_we = in_req_i.has_byte && stg_room;
              if (!in_req_i.last_byte) begin
                stg_cnt_d = cnt_new;
                ovf_d     = ovf_new;
              end else begin
                ok = (in_req_i.total != 8'd0) && (in_req_i.total <= 8'(MAX_FRAGS)) &&
                     (in_req_i.frag_num < in_req_i.total) && !ovf_new;
                if (ok) begin
                  keep = busy_q && (seq_q == in_req_i.seq_id);
                  if (!keep) begin
                    // A new sequence id drops the running assembly and starts over.
                    e_v     = FCNT_W'(in_req_i.total);
                    b_v     = '0;
                    s_v     = '0;
                    seq_d   = in_req_i.seq_id;
                    stamp_d = in_req_i.now;
                    busy_d  = 1'b1;
                    rs_d    = '0;
                    off_d   = '0;
                  end
                  if (in_req_i.total != 8'(e_v)) begin
                    ok = 1'b0;
                  end else begin
                    if (!b_v[idx_s]) begin
                      b_v[idx_s] = 1'b1;
                      s_v        = s_v + SUM_W'(cnt_new);
                      len_we     = 1'b1;
                      if (cnt_new != '0) begin
                        state_d = S_COPY;
                        n_d     = cnt_new;
                        rd_d    = '0;
                        base_d  = MSG_AW'(idx_s) * MSG_AW'(PAYLOAD_BYTES);
                      end
                    end
                    comp = b_v == full_mask(e_v);
                  end
                  exp_d  = e_v;
                  bits_d = b_v;
                  sum_d  = s_v;
                end
                stg_cnt_d    = '0;
                ovf_d        = 1'b0;
                rsp.kind     = KIND_VERDICT;
                rsp.complete = comp;
                rsp.accepted = ok;
                rsp.msg_len  = comp ? to_len(s_v) : '0;
                produce      = 1'b1;
              end
            end
            CMD_TICK: begin
              rsp.kind = KIND_TICK;
              if (busy_q && (age >= timeout_q)) begin
                busy_d       = 1'b0;
                bits_d       = '0;
                exp_d        = '0;
                seq_d        = '0;
                stamp_d      = '0;
                rs_d         = '0;
                off_d        = '0;
                sum_d        = '0;
                rsp.expired  = 1'b1;
              end else if (complete_now) begin
                rsp.complete = 1'b1;
                rsp.msg_len  = to_len(sum_q);
              end
              produce = 1'b1;
            end
            CMD_READ: begin
              rsp.kind = KIND_READ;
              if (!complete_now) begin
                rsp.read_status = RD_NOT_COMPLETE;
                produce         = 1'b1;
              end else if (sum_q == '0) begin
                rsp.complete    = 1'b1;
                rsp.msg_len     = '0;
                rsp.read_status = RD_EMPTY;
                produce         = 1'b1;
              end else begin
                state_d = S_SEEK1;
              end
            end
            default: ;
          endcase
        end
      end
      S_COPY: begin
        stg_re = rd_q < n_q;
        if (stg_re) begin
          rd_d     = rd_q + CNT_W'(1);
          pend_d   = 1'b1;
          pend_a_d = rd_q[STG_AW-1:0];
        end
        msg_we = pend_q;
        if (!stg_re && pend_q) begin
          state_d = S_IDLE;
        end
      end
      S_SEEK1: begin
        if (seek_step) begin
          rs_d  = rs_q + FCNT_W'(1);
          off_d = '0;
        end else if (seek_end) begin
          // Past the last slot: wrap; a nonzero total length guarantees a byte.
          rs_d  = '0;
          off_d = '0;
        end else begin
          msg_re  = 1'b1;
          off_d   = off_q + CNT_W'(1);
          state_d = S_SEEK2;
        end
      end
      S_SEEK2: begin
        if (seek_step) begin
          rs_d  = rs_q + FCNT_W'(1);
          off_d = '0;
        end else begin
          if (seek_end) begin
            rs_d  = '0;
            off_d = '0;
          end
          rsp.kind        = KIND_READ;
          rsp.complete    = 1'b1;
          rsp.msg_len     = to_len(sum_q);
          rsp.out_byte    = msg_rdata;
          rsp.out_last    = seek_end;
          rsp.read_status = RD_OK;
          produce         = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (produce) begin
      out_valid_d = 1'b1;
      out_d       = rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stg_cnt_q   <= '0;
      ovf_q       <= 1'b0;
      bits_q      <= '0;
      exp_q       <= '0;
      seq_q       <= '0;
      stamp_q     <= '0;
      busy_q      <= 1'b0;
      rs_q        <= '0;
      off_q       <= '0;
      sum_q       <= '0;
      timeout_q   <= 32'd30000;
      n_q         <= '0;
      rd_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      stg_cnt_q   <= stg_cnt_d;
      ovf_q       <= ovf_d;
      bits_q      <= bits_d;
      exp_q       <= exp_d;
      seq_q       <= seq_d;
      stamp_q     <= stamp_d;
      busy_q      <= busy_d;
      rs_q        <= rs_d;
      off_q       <= off_d;
      sum_q       <= sum_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      n_q         <= n_d;
      rd_q        <= rd_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_a_q <= pend_a_d;
    base_q   <= base_d;
    if (len_we) begin
      len_q[len_wa] <= len_wd;
    end
  end

  fre_ram #(
    .WIDTH(8),
    .DEPTH(PAYLOAD_BYTES)
  ) u_stage_ram (
    .clk_i   (clk_i),
    .we_i    (stg_we),
    .waddr_i (stg_wa),
    .wdata_i (in_req_i.data_byte),
    .re_i    (stg_re),
    .raddr_i (stg_ra),
    .rdata_o (stg_rdata)
  );

  fre_ram #(
    .WIDTH(8),
    .DEPTH(MSG_D)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (msg_we),
    .waddr_i (msg_wa),
    .wdata_i (stg_rdata),
    .re_i    (msg_re),
    .raddr_i (msg_ra),
    .rdata_o (msg_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `FRE_ASSERT_SAME(a_idle_mask_clear, !busy_q, bits_q == '0, "received mask set while no assembly runs")
  `FRE_ASSERT_SAME(a_copy_bound, state_q == S_COPY, rd_q <= n_q, "copy pointer ran past the staged length")
  `FRE_ASSERT_SAME(a_read_complete, state_q == S_SEEK1 || state_q == S_SEEK2, complete_now && (sum_q != '0), "read walk without a complete message")
  `FRE_ASSERT_NEXT(a_copy_blocks, state_q == S_COPY, !(in_valid_i && !in_stall_o) || state_q == S_IDLE, "request taken during a copy")

endmodule

[sv/fre_ram.sv]
module fre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
